@@ src/pressure_sensor_compensation_top_defines.svh @@
// Assertion macros for the pressure sensor compensation block.
// Included by the top level; no other dependencies.
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/psc_pkg.sv @@
// Shared types, constants and helpers for the pressure sensor compensation block.
// No dependencies; the module files refer to it by scoped names.
package psc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMP_TC   = 3'd5,
    REG_MODEL     = 3'd6
  } cfg_reg_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [23:0]        RAW_P_MIN   = 24'd2000000;
  localparam logic [23:0]        RAW_T_MIN   = 24'd3000000;
  localparam logic signed [19:0] TEMP_REF    = 20'sd2000;
  localparam logic signed [19:0] VCOLD_SHIFT = 20'sd1500;
  localparam logic signed [19:0] VCOLD_LIM   = -20'sd1599;
  localparam logic signed [19:0] TEMP_LO     = -20'sd1000;
  localparam logic signed [19:0] TEMP_HI     = 20'sd6000;
  localparam logic signed [19:0] TEMP_SAT_HI = 20'sd131071;
  localparam logic signed [19:0] TEMP_SAT_LO = -20'sd131072;
  localparam logic signed [47:0] PMIN_M0     = 48'sd1000;
  localparam logic signed [47:0] PMIN_M1     = 48'sd10000;
  localparam logic signed [47:0] P_SAT_HI    = 48'sd2147483647;
  localparam logic signed [47:0] P_SAT_LO    = -48'sd2147483648;

  typedef struct packed {
    logic [15:0] sensitivity_coeff;
    logic [15:0] offset_coeff;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temp_coeff;
    logic [15:0] temp_slope_coeff;
    logic        model_select;
  } cfg_t;

  typedef struct packed {
    logic [23:0] pressure_raw;
    logic [23:0] temperature_raw;
  } sample_t;

  // First-order results
  typedef struct packed {
    logic [23:0]        d1;
    logic               raw_bad;
    logic signed [39:0] sens1;
    logic signed [39:0] off1;
    logic signed [19:0] temp1;
    logic signed [17:0] dev;
    logic               cold;
    logic               vcold;
    logic [16:0]        ti;
  } first_t;

  // Second-order corrected terms
  typedef struct packed {
    logic [23:0]        d1;
    logic               raw_bad;
    logic signed [39:0] sens;
    logic signed [39:0] off;
    logic signed [17:0] temp_sat;
    logic               temp_bad;
  } corr_t;

  typedef struct packed {
    logic signed [17:0] temperature_centi;
    logic signed [31:0] pressure_scaled;
    logic               raw_anomaly;
    logic               range_anomaly;
  } result_t;

  // Arithmetic right shift that rounds toward zero
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
                                                   input logic [5:0] sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

@@ src/psc_if.sv @@
// Stream interfaces for the sample and result channels.
// Depends on nothing; payload widths follow the field list of the block.
interface psc_sample_if;
  logic        valid;
  logic        ready;
  logic [23:0] pressure_raw;
  logic [23:0] temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface psc_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] temperature_centi;
  logic signed [31:0] pressure_scaled;
  logic               raw_anomaly;
  logic               range_anomaly;

  modport source (output valid, output temperature_centi, output pressure_scaled,
                  output raw_anomaly, output range_anomaly, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_scaled,
                  input raw_anomaly, input range_anomaly, output ready);
endinterface

@@ src/psc_first.sv @@
// First-order compensation: dT, the calibration products and the dT-squared term.
// Three register stages; uses psc_pkg types and helpers.
module psc_first (
  input  logic            clk,
  input  logic            rst,
  input  psc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  psc_pkg::sample_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output psc_pkg::first_t out_data
);

  logic [2:0] vld;
  logic [2:0] adv;

  // stage 0
  logic signed [24:0] dt_in;
  logic               raw_in;
  logic [23:0]        d1_0;
  logic signed [24:0] dt_0;
  logic               raw_0;

  // stage 1
  logic [23:0]        d1_1;
  logic               raw_1;
  logic signed [41:0] p3_1;
  logic signed [41:0] p4_1;
  logic signed [41:0] p6_1;
  logic signed [49:0] dt2_1;

  // stage 2 logic
  logic signed [63:0] sh3;
  logic signed [63:0] sh4;
  logic signed [63:0] sh6;
  logic signed [39:0] base_s;
  logic signed [39:0] base_o;
  logic signed [17:0] dev;
  logic signed [19:0] temp1;
  logic               cold;
  logic [48:0]        dt2u;
  logic [52:0]        t11;
  logic [50:0]        t3;
  logic [16:0]        ti;
  psc_pkg::first_t    first_next;

  assign adv[2]    = !vld[2] || out_ready;
  assign adv[1]    = !vld[1] || adv[2];
  assign adv[0]    = !vld[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  assign dt_in  = $signed({1'b0, in_data.temperature_raw})
                - $signed({1'b0, cfg.reference_temp_coeff, 8'h00});
  assign raw_in = (in_data.pressure_raw < psc_pkg::RAW_P_MIN)
               || (in_data.temperature_raw < psc_pkg::RAW_T_MIN);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_0  <= in_data.pressure_raw;
      dt_0  <= dt_in;
      raw_0 <= raw_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_1  <= d1_0;
      raw_1 <= raw_0;
      p3_1  <= $signed({1'b0, cfg.sens_temp_coeff}) * dt_0;
      p4_1  <= $signed({1'b0, cfg.offset_temp_coeff}) * dt_0;
      p6_1  <= $signed({1'b0, cfg.temp_slope_coeff}) * dt_0;
      dt2_1 <= dt_0 * dt_0;
    end
  end

  always_comb begin
    sh3    = psc_pkg::shr_trunc(64'(p3_1), cfg.model_select ? 6'd7 : 6'd8);
    sh4    = psc_pkg::shr_trunc(64'(p4_1), cfg.model_select ? 6'd6 : 6'd7);
    sh6    = psc_pkg::shr_trunc(64'(p6_1), 6'd23);
    base_s = cfg.model_select ? $signed({8'h00, cfg.sensitivity_coeff, 16'h0000})
                              : $signed({9'h000, cfg.sensitivity_coeff, 15'h0000});
    base_o = cfg.model_select ? $signed({7'h00, cfg.offset_coeff, 17'h00000})
                              : $signed({8'h00, cfg.offset_coeff, 16'h0000});
    dev    = sh6[17:0];
    temp1  = $signed({{2{dev[17]}}, dev}) + psc_pkg::TEMP_REF;
    cold   = dev[17];
    // dT squared is never negative
    dt2u   = dt2_1[48:0];
    t11    = (53'(dt2u) << 3) + (53'(dt2u) << 1) + 53'(dt2u);
    t3     = (51'(dt2u) << 1) + 51'(dt2u);
    if (cfg.model_select) begin
      ti = cold ? t11[51:35] : 17'd0;
    end else begin
      ti = cold ? t3[49:33] : {4'h0, dt2u[48:36]};
    end

    first_next.d1    = d1_1;
    first_next.raw_bad = raw_1;
    first_next.sens1 = base_s + $signed(sh3[39:0]);
    first_next.off1  = base_o + $signed(sh4[39:0]);
    first_next.temp1 = temp1;
    first_next.dev   = dev;
    first_next.cold  = cold;
    first_next.vcold = temp1 < psc_pkg::VCOLD_LIM;
    first_next.ti    = ti;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) out_data <= first_next;
  end

endmodule

@@ src/psc_second.sv @@
// Second-order corrections: squares of the deviation, correction terms, final temperature.
// Two register stages; uses psc_pkg types.
module psc_second (
  input  logic            clk,
  input  logic            rst,
  input  psc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  psc_pkg::first_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output psc_pkg::corr_t  out_data
);

  logic [1:0] vld;
  logic [1:0] adv;

  logic signed [35:0] dd;
  logic signed [19:0] e_in;
  logic signed [39:0] ee;

  // stage 0
  logic [23:0]        d1_0;
  logic               raw_0;
  logic signed [39:0] sens1_0;
  logic signed [39:0] off1_0;
  logic signed [19:0] tfin_0;
  logic               cold_0;
  logic               vcold_0;
  logic [34:0]        dev2_0;
  logic [34:0]        e2_0;

  // stage 1 logic
  logic [39:0]        d;
  logic [39:0]        e2x;
  logic [39:0]        offi;
  logic [39:0]        sensi;
  psc_pkg::corr_t     corr_next;

  assign adv[1]    = !vld[1] || out_ready;
  assign adv[0]    = !vld[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
    end
  end

  assign dd   = in_data.dev * in_data.dev;
  assign e_in = in_data.temp1 + psc_pkg::VCOLD_SHIFT;
  assign ee   = e_in * e_in;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_0    <= in_data.d1;
      raw_0   <= in_data.raw_bad;
      sens1_0 <= in_data.sens1;
      off1_0  <= in_data.off1;
      tfin_0  <= in_data.temp1 - $signed({3'b000, in_data.ti});
      cold_0  <= in_data.cold;
      vcold_0 <= in_data.vcold;
      dev2_0  <= dd[34:0];
      e2_0    <= ee[34:0];
    end
  end

  always_comb begin
    d   = 40'(dev2_0);
    e2x = 40'(e2_0);
    if (cfg.model_select) begin
      offi  = cold_0 ? (((d << 5) - d) >> 3) : 40'd0;
      sensi = cold_0 ? (((d << 6) - d) >> 5) : 40'd0;
    end else if (cold_0) begin
      offi  = (((d << 1) + d) >> 1) + (vcold_0 ? ((e2x << 3) - e2x) : 40'd0);
      sensi = (((d << 2) + d) >> 3) + (vcold_0 ? (e2x << 2) : 40'd0);
    end else begin
      offi  = d >> 4;
      sensi = 40'd0;
    end

    corr_next.d1       = d1_0;
    corr_next.raw_bad  = raw_0;
    corr_next.sens     = sens1_0 - $signed(sensi);
    corr_next.off      = off1_0 - $signed(offi);
    corr_next.temp_bad = (tfin_0 < psc_pkg::TEMP_LO) || (tfin_0 > psc_pkg::TEMP_HI);
    if (tfin_0 > psc_pkg::TEMP_SAT_HI) begin
      corr_next.temp_sat = 18'sh1FFFF;
    end else if (tfin_0 < psc_pkg::TEMP_SAT_LO) begin
      corr_next.temp_sat = 18'sh20000;
    end else begin
      corr_next.temp_sat = tfin_0[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) out_data <= corr_next;
  end

endmodule

@@ src/psc_press.sv @@
// Pressure path: split product of D1 and SENS, scaling, offset, range check, saturation.
// Six register stages, the last one is the output register; uses psc_pkg types.
module psc_press (
  input  logic             clk,
  input  logic             rst,
  input  psc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  psc_pkg::corr_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output psc_pkg::result_t out_data
);

  typedef struct packed {
    logic signed [17:0] temp_sat;
    logic               temp_bad;
    logic               raw_bad;
  } side_t;

  logic [5:0] vld;
  logic [5:0] adv;

  side_t side_in;
  side_t side_0, side_1, side_2, side_3, side_4;

  logic [43:0]        pp_lo_0;
  logic signed [44:0] pp_hi_0;
  logic signed [39:0] off_0, off_1, off_2;
  logic signed [63:0] prod_1;
  logic signed [63:0] quot_full;
  logic signed [47:0] quot_2;
  logic signed [47:0] p_3;
  logic signed [63:0] pq_full;
  logic signed [47:0] pq_4;
  logic signed [47:0] pmin;
  psc_pkg::result_t   result_next;

  assign adv[5]    = !vld[5] || out_ready;
  assign adv[4]    = !vld[4] || adv[5];
  assign adv[3]    = !vld[3] || adv[4];
  assign adv[2]    = !vld[2] || adv[3];
  assign adv[1]    = !vld[1] || adv[2];
  assign adv[0]    = !vld[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
      if (adv[5]) vld[5] <= vld[4];
    end
  end

  assign side_in.temp_sat = in_data.temp_sat;
  assign side_in.temp_bad = in_data.temp_bad;
  assign side_in.raw_bad  = in_data.raw_bad;

  // Split SENS into a low unsigned half and a high signed half
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pp_lo_0 <= in_data.d1 * in_data.sens[19:0];
      pp_hi_0 <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);
      off_0   <= in_data.off;
      side_0  <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod_1 <= (64'(pp_hi_0) <<< 20) + $signed({20'h00000, pp_lo_0});
      off_1  <= off_0;
      side_1 <= side_0;
    end
  end

  assign quot_full = psc_pkg::shr_trunc(prod_1, 6'd21);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      quot_2 <= quot_full[47:0];
      off_2  <= off_1;
      side_2 <= side_1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p_3    <= quot_2 - 48'(off_2);
      side_3 <= side_2;
    end
  end

  assign pq_full = psc_pkg::shr_trunc(64'(p_3), cfg.model_select ? 6'd15 : 6'd13);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pq_4   <= pq_full[47:0];
      side_4 <= side_3;
    end
  end

  always_comb begin
    pmin = cfg.model_select ? psc_pkg::PMIN_M1 : psc_pkg::PMIN_M0;
    result_next.temperature_centi = side_4.temp_sat;
    result_next.raw_anomaly       = side_4.raw_bad;
    result_next.range_anomaly     = side_4.temp_bad || (pq_4 < pmin);
    if (pq_4 > psc_pkg::P_SAT_HI) begin
      result_next.pressure_scaled = 32'sh7FFFFFFF;
    end else if (pq_4 < psc_pkg::P_SAT_LO) begin
      result_next.pressure_scaled = 32'sh80000000;
    end else begin
      result_next.pressure_scaled = pq_4[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) out_data <= result_next;
  end

endmodule

@@ src/pressure_sensor_compensation_top.sv @@
// Top level of the pressure sensor compensation block: calibration registers and pipeline.
// Depends on psc_pkg, psc_if, psc_first, psc_second, psc_press and the defines header.
//
//   channel      dir   beat contents
//   sample_in    in    pressure_raw, temperature_raw
//   result_out   out   temperature_centi, pressure_scaled, raw_anomaly, range_anomaly
//   cfg_wr_*     in    register index and 16-bit data, one write per cycle
//
// Samples pass through psc_first, psc_second and psc_press; one beat enters per cycle unless the pipe backs up.
// The pipeline depth is set by the split D1 x SENS product and the truncating shifts after it.
// Reset clears the valid bits and sets every calibration register to zero.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up
// under a stalled output and nothing is dropped or repeated.
`include "pressure_sensor_compensation_top_defines.svh"

module pressure_sensor_compensation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  psc_sample_if.sink                          sample_in,
  psc_result_if.source                        result_out
);

  psc_pkg::cfg_t    cfg;
  psc_pkg::sample_t sample;
  psc_pkg::first_t  first_data;
  psc_pkg::corr_t   corr_data;
  psc_pkg::result_t result;

  logic first_valid, first_ready;
  logic corr_valid, corr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psc_pkg::REG_SENS:      cfg.sensitivity_coeff    <= cfg_wr_data;
        psc_pkg::REG_OFFSET:    cfg.offset_coeff         <= cfg_wr_data;
        psc_pkg::REG_SENS_TC:   cfg.sens_temp_coeff      <= cfg_wr_data;
        psc_pkg::REG_OFFSET_TC: cfg.offset_temp_coeff    <= cfg_wr_data;
        psc_pkg::REG_TREF:      cfg.reference_temp_coeff <= cfg_wr_data;
        psc_pkg::REG_TEMP_TC:   cfg.temp_slope_coeff     <= cfg_wr_data;
        psc_pkg::REG_MODEL:     cfg.model_select         <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign sample.pressure_raw    = sample_in.pressure_raw;
  assign sample.temperature_raw = sample_in.temperature_raw;

  psc_first u_first (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .in_data   (sample),
    .out_valid (first_valid),
    .out_ready (first_ready),
    .out_data  (first_data)
  );

  psc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (first_valid),
    .in_ready  (first_ready),
    .in_data   (first_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  psc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result)
  );

  assign result_out.temperature_centi = result.temperature_centi;
  assign result_out.pressure_scaled   = result.pressure_scaled;
  assign result_out.raw_anomaly       = result.raw_anomaly;
  assign result_out.range_anomaly     = result.range_anomaly;

  // An empty output stage must open the whole pipe to new samples
  `PSC_ASSERT_IMPL(a_ready_when_empty, clk, rst, !result_out.valid, sample_in.ready, "sample_in not ready with empty output")

  // Saturation keeps order, so an out-of-band temperature must carry the range flag
  `PSC_ASSERT_IMPL(a_temp_flag, clk, rst, result_out.valid && (result_out.temperature_centi > 18'sd6000 || result_out.temperature_centi < -18'sd1000), result_out.range_anomaly, "temperature out of band without range flag")

  `PSC_ASSERT_IMPL(a_press_flag_m0, clk, rst, result_out.valid && !cfg.model_select && result_out.pressure_scaled < 32'sd1000, result_out.range_anomaly, "low pressure without range flag, model 0")

  `PSC_ASSERT_IMPL(a_press_flag_m1, clk, rst, result_out.valid && cfg.model_select && result_out.pressure_scaled < 32'sd10000, result_out.range_anomaly, "low pressure without range flag, model 1")

endmodule
